// ===== src/lsp_pkg.sv =====
// Shared constants, types and helper functions of the LSP synthesis filter.
// No dependencies; every other file of the block imports this package.
package lsp_pkg;

  localparam int MAX_SECTIONS = 16;
  localparam int SLOTS        = MAX_SECTIONS + 1;
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CP_W         = $clog2(SLOTS + 1);

  localparam int PARAM_W   = 16;
  localparam int PIDX_W    = 5;
  localparam int SAMPLE_W  = 16;
  localparam int STATE_W   = 32;
  localparam int COEF_W    = 17;
  localparam int PROD_W    = COEF_W + STATE_W;
  localparam int ACC_W     = 40;
  localparam int NUM_W     = 32;
  localparam int SC_W      = 5;
  localparam int FL_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTION_COUNT = 1'b0,
    CFG_FRAME_LENGTH  = 1'b1
  } cfg_reg_t;

  // Angle used by section i of an n-section cascade (interleaved order).
  function automatic logic [SEC_W-1:0] perm_index(input logic [SEC_W-1:0] i,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W+1:0] ii, nn, hi, odd, k;
    ii  = (CNT_W+2)'(i);
    nn  = (CNT_W+2)'(n);
    hi  = ii >> 1;
    odd = (CNT_W+2)'(n[0]);
    if (ii[1]) begin
      k = ii[0] ? (nn - hi - odd) : (nn - hi - (CNT_W+2)'(1) + odd);
    end else begin
      k = ii[0] ? (hi + (CNT_W+2)'(1)) : hi;
    end
    return (k < nn) ? SEC_W'(k) : SEC_W'(nn - (CNT_W+2)'(1));
  endfunction

  function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
    return !((&v[ACC_W-1:STATE_W-1]) || !(|v[ACC_W-1:STATE_W-1]));
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (ovf32(v)) begin
      return v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end
    return v[STATE_W-1:0];
  endfunction

endpackage

// ===== src/lsp_if.sv =====
// Request and result channel interfaces of the LSP synthesis filter.
// Depends on lsp_pkg for the field widths.
interface lsp_req_if import lsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [PIDX_W-1:0]          param_index;
  logic [PARAM_W-1:0]         param_value;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, cmd, param_index, param_value, sample_in, input ready);
  modport sink   (input valid, cmd, param_index, param_value, sample_in, output ready);
endinterface

interface lsp_res_if import lsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;
  logic                       frame_end;

  modport source (output valid, sample_out, clipped, frame_end, input ready);
  modport sink   (input valid, sample_out, clipped, frame_end, output ready);
endinterface

// ===== src/lsp_div.sv =====
// Restoring divider for parameter interpolation, one quotient bit a cycle.
// Depends on lsp_pkg; numerator must be below den * 2^16.
module lsp_div import lsp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [FL_W-1:0]    den,
  output logic               done,
  output logic [PARAM_W-1:0] quot
);
  localparam int STEP_W = $clog2(PARAM_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [FL_W-1:0]   rem_r;
  logic [FL_W-1:0]   den_r;
  logic [PARAM_W-1:0] low_r;
  logic [PARAM_W-1:0] quot_r;
  logic [FL_W:0]     trial;
  logic [FL_W:0]     diff;
  logic              fits;

  assign trial = {rem_r, low_r[PARAM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(PARAM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[PARAM_W+FL_W-1:PARAM_W];
      low_r <= num[PARAM_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[FL_W-1:0] : trial[FL_W-1:0];
      low_r  <= {low_r[PARAM_W-2:0], 1'b0};
      quot_r <= {quot_r[PARAM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== src/lsp_cos.sv =====
// Coefficient unit: -2*cos(angle) in Q14 from a Q3.13 angle by a Horner series.
// Depends on lsp_pkg; one partial product or reciprocal step per cycle.
module lsp_cos import lsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [PARAM_W-1:0]       angle,
  output logic                     done,
  output logic signed [COEF_W-1:0] coef
);
  localparam logic [PARAM_W-1:0] TWO_PI  = 16'd51472;
  localparam logic [PARAM_W-1:0] PI      = 16'd25736;
  localparam logic [PARAM_W-1:0] HALF_PI = 16'd12868;
  localparam int ANG_W = 14;
  localparam int X2_W  = 30;
  localparam int T_W   = 31;
  localparam int FRAC  = 28;
  localparam int LO_W  = 15;
  localparam logic signed [T_W-1:0] ONE = 31'sd268435456;

  typedef enum logic [7:0] {
    C_IDLE = 8'b0000_0001,
    C_SQ   = 8'b0000_0010,
    C_MLO  = 8'b0000_0100,
    C_MHI  = 8'b0000_1000,
    C_SUM  = 8'b0001_0000,
    C_RCP  = 8'b0010_0000,
    C_COR  = 8'b0100_0000,
    C_FIN  = 8'b1000_0000
  } cos_state_t;

  // Horner divisors, innermost first, and floor(2^32 / divisor).
  function automatic logic [5:0] step_div(input logic [1:0] s);
    case (s)
      2'd0:    return 6'd56;
      2'd1:    return 6'd30;
      2'd2:    return 6'd12;
      default: return 6'd2;
    endcase
  endfunction

  function automatic logic [31:0] step_recip(input logic [1:0] s);
    case (s)
      2'd0:    return 32'd76695844;
      2'd1:    return 32'd143165576;
      2'd2:    return 32'd357913941;
      default: return 32'd2147483648;
    endcase
  endfunction

  cos_state_t               state_r;
  logic [ANG_W-1:0]         ang_r;
  logic                     flip_r;
  logic [X2_W-1:0]          x2_r;
  logic signed [T_W-1:0]    t_r;
  logic [1:0]               step_r;
  logic [X2_W+LO_W-1:0]     plo_r;
  logic [X2_W+FRAC-LO_W:0]  phi_r;
  logic [X2_W-1:0]          v_r;
  logic [X2_W-1:0]          q0_r;
  logic                     done_r;
  logic signed [COEF_W-1:0] coef_r;

  logic [PARAM_W-1:0] a1, a2, a3;
  logic               fold_flip;
  logic [58:0]        psum;
  logic [61:0]        rprod;
  logic [35:0]        qk;
  logic [35:0]        rem;
  logic               qadj;
  logic signed [T_W-1:0] tc;
  logic [T_W-1:0]     tr;

  always_comb begin
    a1        = (angle >= TWO_PI) ? angle - TWO_PI : angle;
    a2        = (a1 > PI) ? TWO_PI - a1 : a1;
    fold_flip = (a2 > HALF_PI);
    a3        = fold_flip ? PI - a2 : a2;
    psum      = {phi_r, {LO_W{1'b0}}} + 59'(plo_r);
    rprod     = 62'(v_r) * 62'(step_recip(step_r));
    qk        = 36'(q0_r) * 36'(step_div(step_r));
    rem       = 36'(v_r) - qk;
    qadj      = (rem >= 36'(step_div(step_r)));
    if (t_r < 0) begin
      tc = '0;
    end else if (t_r > ONE) begin
      tc = ONE;
    end else begin
      tc = t_r;
    end
    tr = T_W'(tc) + T_W'(8192);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: if (start) state_r <= C_SQ;
        C_SQ: begin
          step_r  <= '0;
          state_r <= C_MLO;
        end
        C_MLO: state_r <= C_MHI;
        C_MHI: state_r <= C_SUM;
        C_SUM: state_r <= C_RCP;
        C_RCP: state_r <= C_COR;
        C_COR: begin
          step_r  <= step_r + 2'd1;
          state_r <= (step_r == 2'd3) ? C_FIN : C_MLO;
        end
        C_FIN: begin
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: begin
        ang_r  <= a3[ANG_W-1:0];
        flip_r <= fold_flip;
      end
      C_SQ: begin
        x2_r <= {28'(ang_r * ang_r), 2'b00};
        t_r  <= ONE;
      end
      C_MLO: plo_r <= x2_r * t_r[LO_W-1:0];
      C_MHI: phi_r <= x2_r * t_r[FRAC:LO_W];
      C_SUM: v_r   <= psum[FRAC+X2_W-1:FRAC];
      C_RCP: q0_r  <= rprod[61:32];
      C_COR: t_r   <= ONE - $signed(T_W'(q0_r) + T_W'(qadj));
      C_FIN: coef_r <= flip_r ? $signed({1'b0, tr[FRAC:14], 1'b0})
                              : -$signed({1'b0, tr[FRAC:14], 1'b0});
      default: ;
    endcase
  end

  assign done = done_r;
  assign coef = coef_r;

endmodule

// ===== src/lsp_synthesis_filter_top.sv =====
// LSP all-pole speech synthesis filter, top level: sequencer, parameter and
// delay memories, section datapath. Depends on lsp_pkg, lsp_if, lsp_div, lsp_cos.
//
// Use: requests arrive on in_if (valid/ready). A request with cmd low writes one
// parameter of the next frame (slot 0 gain Q4.12, slots 1..16 angles Q3.13);
// slots above 16 are dropped. A request with cmd high carries one excitation
// sample and yields exactly one result on out_if: the synthesized sample, a
// clip flag and a frame-end flag. Configuration (section count, frame length)
// is written on cfg_we/cfg_index/cfg_data while the block is idle.
// Sequence: a parameter write reads its slot and then writes it back. A sample
// passes through setup and gain, then for each section the interpolation
// divider, the cosine unit and the two multiplies and write-back, then output.
// The next request is taken in the same cycle that the result appears unless the
// sample ends a frame. The first sample after reset and the last sample of every
// frame add a copy sweep of the parameter memory (next into previous).
// Reset (synchronous, rst_n low) clears the filter state through valid bits on
// the delay memory and restores section count 10 and frame length 160.
// Results sit in an output register; while the receiver stalls, the block
// still takes the next request and holds its result until the register frees.
module lsp_synthesis_filter_top import lsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lsp_req_if.sink              in_if,
  lsp_res_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000_0000_0000_0001,
    ST_LOAD  = 15'b000_0000_0000_0010,
    ST_COPY  = 15'b000_0000_0000_0100,
    ST_SETUP = 15'b000_0000_0000_1000,
    ST_PRD   = 15'b000_0000_0001_0000,
    ST_PMUL  = 15'b000_0000_0010_0000,
    ST_PSUM  = 15'b000_0000_0100_0000,
    ST_DIV   = 15'b000_0000_1000_0000,
    ST_GAIN  = 15'b000_0001_0000_0000,
    ST_COS   = 15'b000_0010_0000_0000,
    ST_SA    = 15'b000_0100_0000_0000,
    ST_SB    = 15'b000_1000_0000_0000,
    ST_SC    = 15'b001_0000_0000_0000,
    ST_TAIL  = 15'b010_0000_0000_0000,
    ST_OUT   = 15'b100_0000_0000_0000
  } top_state_t;

  top_state_t state_r, state_nxt;

  // configuration
  logic [SC_W-1:0] sc_r;
  logic [FL_W-1:0] fl_r;

  // sequencing
  logic             primed_r;
  logic [FL_W-1:0]  sample_pos_r;
  logic [CNT_W-1:0] n_r;
  logic [FL_W-1:0]  len_r;
  logic [FL_W-1:0]  pos_r;
  logic             last_r;
  logic             gain_ph_r;
  logic [SEC_W-1:0] sec_r;
  logic [CP_W-1:0]  cp_cnt_r;
  logic             copy_prime_r;
  logic [SLOT_W-1:0] ld_idx_r;
  logic [PARAM_W-1:0] ld_val_r;

  // datapath
  logic signed [SAMPLE_W-1:0] ex_r;
  logic [NUM_W-1:0]           pa_r;
  logic signed [SAMPLE_W+PARAM_W:0] drive_r;
  logic signed [STATE_W-1:0]  out1_r [2];
  logic signed [STATE_W-1:0]  out2_r [2];
  logic signed [STATE_W-1:0]  lo_r;
  logic signed [STATE_W-1:0]  tail_r;
  logic signed [PROD_W-1:0]   m_r;
  logic                       clip_r;

  // output register
  logic                       ov_r;
  logic signed [SAMPLE_W-1:0] osamp_r;
  logic                       oclip_r;
  logic                       oend_r;

  // parameter memory: {next, previous} per slot
  logic [2*PARAM_W-1:0] pm_mem [SLOTS];
  logic [2*PARAM_W-1:0] pm_q_r;
  logic                 pm_re, pm_we;
  logic [SLOT_W-1:0]    pm_ra, pm_wa;
  logic [2*PARAM_W-1:0] pm_wd;
  logic [PARAM_W-1:0]   pm_next, pm_prev;

  // delay memory: {delay two, delay one} per section, zero until written
  logic [2*STATE_W-1:0]    dm_mem [MAX_SECTIONS];
  logic [2*STATE_W-1:0]    dm_q_r;
  logic [MAX_SECTIONS-1:0] dv_r;
  logic                    dm_re;
  logic signed [STATE_W-1:0] z0, d2;

  // units
  logic                     div_start, div_done;
  logic [NUM_W-1:0]         div_num;
  logic [PARAM_W-1:0]       div_quot;
  logic                     cos_start, cos_done;
  logic signed [COEF_W-1:0] coef;

  logic in_acc, out_space, idx_ok, p_sel, sec_last;
  logic [FL_W-1:0]  len_c, pos_c;
  logic [CNT_W-1:0] n_c;
  logic signed [SAMPLE_W+PARAM_W:0] gprod;
  logic signed [ACC_W-1:0] sum2, sum1, fpre, fout, dsum, yv;
  logic ysat;

  assign in_acc    = in_if.valid && in_if.ready;
  assign out_space = !ov_r || out_if.ready;
  assign idx_ok    = (int'(in_if.param_index) <= MAX_SECTIONS);
  assign p_sel     = sec_r[0];
  assign sec_last  = (CNT_W'(sec_r) == n_r - CNT_W'(1));
  assign pm_next   = pm_q_r[2*PARAM_W-1:PARAM_W];
  assign pm_prev   = pm_q_r[PARAM_W-1:0];
  assign z0 = dv_r[sec_r] ? $signed(dm_q_r[STATE_W-1:0]) : '0;
  assign d2 = dv_r[sec_r] ? $signed(dm_q_r[2*STATE_W-1:STATE_W]) : '0;

  always_comb begin
    len_c = (fl_r == '0) ? FL_W'(1) : fl_r;
    pos_c = (sample_pos_r >= len_c) ? len_c - FL_W'(1) : sample_pos_r;
    n_c   = (int'(sc_r) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS) : CNT_W'(sc_r);
    div_num = pa_r + (NUM_W'(len_r - pos_r) * NUM_W'(pm_prev)) + NUM_W'(len_r >> 1);
    gprod = $signed({1'b0, div_quot}) * ex_r;
    sum2  = ACC_W'(out2_r[p_sel]) + ACC_W'((m_r + PROD_W'(8192)) >>> 14) + ACC_W'(z0);
    sum1  = ACC_W'(out1_r[p_sel]) + ACC_W'((m_r + PROD_W'(8192)) >>> 14) + ACC_W'(d2);
    if (n_r[0]) begin
      fpre = ACC_W'(out2_r[0]) + ACC_W'(out2_r[1]) - ACC_W'(tail_r);
    end else begin
      fpre = ACC_W'(out1_r[0]) - ACC_W'(out1_r[1]) + ACC_W'(out2_r[0]) + ACC_W'(out2_r[1]);
    end
    fout = (fpre + ACC_W'(1)) >>> 1;
    dsum = ACC_W'(drive_r) - fout;
    yv   = (ACC_W'(lo_r) + ACC_W'(256)) >>> 9;
    ysat = !((&yv[ACC_W-1:SAMPLE_W-1]) || !(|yv[ACC_W-1:SAMPLE_W-1]));
  end

  // memory port control and next state
  always_comb begin
    state_nxt = state_r;
    pm_re = 1'b0;
    pm_ra = '0;
    pm_we = 1'b0;
    pm_wa = '0;
    pm_wd = '0;
    dm_re = 1'b0;
    div_start = 1'b0;
    cos_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_if.cmd) begin
            if (idx_ok) begin
              pm_re     = 1'b1;
              pm_ra     = SLOT_W'(in_if.param_index);
              state_nxt = ST_LOAD;
            end
          end else begin
            state_nxt = primed_r ? ST_SETUP : ST_COPY;
          end
        end
      end
      ST_LOAD: begin
        pm_we     = 1'b1;
        pm_wa     = ld_idx_r;
        pm_wd     = {ld_val_r, pm_prev};
        state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        if (cp_cnt_r < CP_W'(SLOTS)) begin
          pm_re = 1'b1;
          pm_ra = SLOT_W'(cp_cnt_r);
        end
        if (cp_cnt_r != '0) begin
          pm_we = 1'b1;
          pm_wa = SLOT_W'(cp_cnt_r - CP_W'(1));
          pm_wd = {pm_next, pm_next};
        end
        if (cp_cnt_r == CP_W'(SLOTS)) begin
          state_nxt = copy_prime_r ? ST_SETUP : ST_IDLE;
        end
      end
      ST_SETUP: state_nxt = ST_PRD;
      ST_PRD: begin
        pm_re     = 1'b1;
        pm_ra     = gain_ph_r ? '0 : SLOT_W'(perm_index(sec_r, n_r)) + SLOT_W'(1);
        dm_re     = !gain_ph_r;
        state_nxt = ST_PMUL;
      end
      ST_PMUL: state_nxt = ST_PSUM;
      ST_PSUM: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          cos_start = !gain_ph_r;
          state_nxt = gain_ph_r ? ST_GAIN : ST_COS;
        end
      end
      ST_GAIN: state_nxt = (n_r == '0) ? ST_TAIL : ST_PRD;
      ST_COS:  if (cos_done) state_nxt = ST_SA;
      ST_SA:   state_nxt = ST_SB;
      ST_SB:   state_nxt = ST_SC;
      ST_SC:   state_nxt = sec_last ? ST_TAIL : ST_PRD;
      ST_TAIL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_space) begin
          state_nxt = last_r ? ST_COPY : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (pm_we) pm_mem[pm_wa] <= pm_wd;
    if (pm_re) pm_q_r <= pm_mem[pm_ra];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SC) dm_mem[sec_r] <= {z0, out1_r[p_sel]};
    if (dm_re) dm_q_r <= dm_mem[sec_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sc_r         <= SC_W'(10);
      fl_r         <= FL_W'(160);
      primed_r     <= 1'b0;
      sample_pos_r <= '0;
      dv_r         <= '0;
      lo_r         <= '0;
      tail_r       <= '0;
      ov_r         <= 1'b0;
      cp_cnt_r     <= '0;
      copy_prime_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SECTION_COUNT: sc_r <= cfg_data[SC_W-1:0];
          CFG_FRAME_LENGTH:  fl_r <= cfg_data[FL_W-1:0];
          default: ;
        endcase
      end
      // start a copy sweep: priming on the first sample, or at frame end
      if (state_r == ST_IDLE && in_acc && in_if.cmd && !primed_r) begin
        cp_cnt_r     <= '0;
        copy_prime_r <= 1'b1;
      end else if (state_r == ST_OUT && out_space && last_r) begin
        cp_cnt_r     <= '0;
        copy_prime_r <= 1'b0;
      end else if (state_r == ST_COPY) begin
        cp_cnt_r <= cp_cnt_r + CP_W'(1);
        if (cp_cnt_r == CP_W'(SLOTS) && copy_prime_r) primed_r <= 1'b1;
      end
      if (state_r == ST_SC) dv_r[sec_r] <= 1'b1;
      if (state_r == ST_TAIL) begin
        lo_r <= sat32(dsum);
        if (n_r[0]) tail_r <= out1_r[1];
      end
      if (state_r == ST_OUT && out_space) begin
        ov_r         <= 1'b1;
        sample_pos_r <= last_r ? '0 : pos_r + FL_W'(1);
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ld_idx_r <= SLOT_W'(in_if.param_index);
          ld_val_r <= in_if.param_value;
          ex_r     <= in_if.sample_in;
          clip_r   <= 1'b0;
        end
      end
      ST_SETUP: begin
        n_r       <= n_c;
        len_r     <= len_c;
        pos_r     <= pos_c;
        last_r    <= (pos_c == len_c - FL_W'(1));
        gain_ph_r <= 1'b1;
        out1_r[0] <= lo_r;
        out1_r[1] <= lo_r;
        out2_r[0] <= '0;
        out2_r[1] <= '0;
      end
      ST_PMUL: pa_r <= NUM_W'(pos_r) * NUM_W'(pm_next);
      ST_GAIN: begin
        drive_r   <= (gprod + 33'sd4) >>> 3;
        gain_ph_r <= 1'b0;
        sec_r     <= '0;
      end
      ST_SA: m_r <= coef * out1_r[p_sel];
      ST_SB: begin
        out2_r[p_sel] <= sat32(sum2);
        clip_r        <= clip_r | ovf32(sum2);
        m_r           <= coef * z0;
      end
      ST_SC: begin
        out1_r[p_sel] <= sat32(sum1);
        clip_r        <= clip_r | ovf32(sum1);
        sec_r         <= sec_r + SEC_W'(1);
      end
      ST_TAIL: clip_r <= clip_r | ovf32(dsum);
      ST_OUT: begin
        if (out_space) begin
          osamp_r <= ysat ? (yv[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_W-1){1'b1}}})
                          : yv[SAMPLE_W-1:0];
          oclip_r <= clip_r | ysat;
          oend_r  <= last_r;
        end
      end
      default: ;
    endcase
  end

  lsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (len_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  lsp_cos u_cos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cos_start),
    .angle (div_quot),
    .done  (cos_done),
    .coef  (coef)
  );

  assign in_if.ready       = (state_r == ST_IDLE);
  assign out_if.valid      = ov_r;
  assign out_if.sample_out = osamp_r;
  assign out_if.clipped    = oclip_r;
  assign out_if.frame_end  = oend_r;

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside its wait state");
  a_cos_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cos_done |-> (state_r == ST_COS))
    else $error("cosine unit finished outside its wait state");
  a_section_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SC) |-> (CNT_W'(sec_r) < n_r))
    else $error("section write-back beyond the section count");
`endif

endmodule
